/* design/lcd_pkg.sv */
// Shared types and constants of the line crossing detector.
package lcd_pkg;

	localparam int FRAME_W    = 13;
	localparam int COOL_W     = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int COORD_W    = 16;
	localparam int MASK_W     = 16;
	localparam int CLS_W      = 4;
	localparam int CAM_W      = 3;
	localparam int IDX_W      = 6;
	localparam int TS_W       = 48;
	localparam int SCALED_W   = 29;
	localparam int OP_A_W     = 34;
	localparam int OP_B_W     = 18;
	localparam int PROD_W     = OP_A_W + OP_B_W;
	localparam int ACC_W      = 68;
	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 16;
	localparam int LINE_ENT_W = 4 * COORD_W + MASK_W + 1;
	localparam int FIRE_ENT_W = TS_W + 1;
	localparam int OUT_MAX    = 4;
	localparam int OUT_CNT_W  = 3;
	localparam int OUT_IDX_W  = 2;
	localparam int STEP_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 2'd2;

	localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
	localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
	localparam logic [COOL_W-1:0]  COOLDOWN_RST     = 16'd3000;
	localparam logic [COOL_W-1:0]  COOLDOWN_MIN     = 16'd100;
	localparam logic [COOL_W-1:0]  COOLDOWN_MAX     = 16'd60000;
	localparam logic [MASK_W-1:0]  MASK_ALL         = 16'hFFFF;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic clr;
		logic hi;
		logic sub;
	} mac_ctl_t;

endpackage

/* design/line_crossing_detector.sv */
// Top level of the line crossing detector: sequencer, tables and stream ports.
//
// Channel   Dir  Handshake         Payload
// s_*       in   tvalid/tready     tuser func, tdata item fields
// m_*       out  tvalid/tready     tdata line_index/track_id/direction, tlast
// cfg_*     in   write enable      register index and data
//
// After reset a clearing pass over the line and cooldown tables runs with s_tready low.
// A load item is written on acceptance; a check item reads each line (S_RDLINE, S_CHKF),
// and for a line that passes the class filter runs 16 multiply/accumulate steps on the
// shared 34x18 multiplier and a decision state (S_GEOM), then S_FIRE if the paths cross.
// Crossings are then emitted one per cycle; m_tready low stalls the emission.

module line_crossing_detector #(
	parameter int CAMERAS = 8,
	parameter int LINES   = 4,
	parameter int TRACKS  = 64,
	parameter int CLASSES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// camera, index, object class, is_new, x0, y0, x1, y1, class_mask,
	// line_enabled, timestamp_ms, zero pad
	input  logic [lcd_pkg::IN_DATA_W-1:0]      s_tdata,
	// func
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// line_index, track_id, direction, zero pad
	output logic [lcd_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [lcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcd_pkg::CFG_W-1:0]          cfg_data
);
	import lcd_pkg::*;

	localparam int SLOTS      = CAMERAS * LINES;
	localparam int SLOT_AW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int FIRE_DEPTH = SLOTS * TRACKS;
	localparam int FIRE_AW    = $clog2(FIRE_DEPTH);
	localparam int LINE_AW    = LINES > 1 ? $clog2(LINES) : 1;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RDLINE = 4'd2;
	localparam logic [3:0] S_CHKF   = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_GEOM   = 4'd5;
	localparam logic [3:0] S_FIRE   = 4'd6;
	localparam logic [3:0] S_EMIT   = 4'd7;

	logic [3:0]            state_q, state_nxt;
	logic [FIRE_AW-1:0]    clr_q;
	logic [FRAME_W-1:0]    fw_q, fh_q;
	logic [COOL_W-1:0]     cool_q, cd;

	logic [CAM_W-1:0]      it_cam_q;
	logic [IDX_W-1:0]      it_idx_q;
	logic [CLS_W-1:0]      it_cls_q;
	logic [COORD_W-1:0]    it_x0_q, it_y0_q, it_x1_q, it_y1_q;
	logic [TS_W-1:0]       it_ts_q;
	logic [COORD_W-1:0]    e_ax_q, e_ay_q, e_bx_q, e_by_q;
	logic [SCALED_W-1:0]   ax_q, ay_q, bx_q, by_q;
	logic                  d1p_q, d1n_q, d2p_q, d2n_q, d3p_q, d3n_q, d4p_q, d4n_q;

	logic [LINE_AW-1:0]    l_q;
	logic [OUT_CNT_W-1:0]  n_q, e_q;
	logic [STEP_W-1:0]     step_q;
	logic                  ph_q;
	logic [LINE_AW-1:0]    res_line_q [OUT_MAX];
	logic                  res_dir_q  [OUT_MAX];
	logic [FIRE_AW-1:0]    fire_addr_q;

	logic                  in_acc;
	logic [CAM_W-1:0]      in_cam;
	logic [IDX_W-1:0]      in_idx;
	logic                  cam_ok;

	logic                  lr_we, lr_re;
	logic [SLOT_AW-1:0]    lr_waddr, lr_raddr;
	logic [LINE_ENT_W-1:0] lr_wdata, lr_rdata;
	logic                  fr_we, fr_re;
	logic [FIRE_AW-1:0]    fr_waddr;
	logic [FIRE_ENT_W-1:0] fr_wdata, fr_rdata;

	logic [MASK_W-1:0]     rd_mask;
	logic                  rd_en, cls_hit;
	logic                  fired, last_line, done_nxt;
	logic [OUT_CNT_W-1:0]  n_nxt;
	logic signed [TS_W:0]  age;

	mac_ctl_t                   mctl;
	logic signed [OP_A_W-1:0]   op_a;
	logic signed [OP_B_W-1:0]   op_b;
	logic signed [ACC_W-1:0]    acc_nxt;
	logic signed [OP_A_W-1:0]   sax, say, sbx, sby, p1x, p1y, p2x, p2y, bax, bay;
	logic signed [OP_B_W-1:0]   dpx, dpy;
	logic                       acc_pos, acc_neg;

	assign in_acc = s_tvalid && s_tready;
	assign in_cam = s_tdata[2:0];
	assign in_idx = s_tdata[8:3];
	assign cam_ok = 32'(in_cam) < CAMERAS;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cd = cool_q;
		if (cool_q < COOLDOWN_MIN) begin
			cd = COOLDOWN_MIN;
		end else if (cool_q > COOLDOWN_MAX) begin
			cd = COOLDOWN_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= FRAME_WIDTH_RST;
			fh_q   <= FRAME_HEIGHT_RST;
			cool_q <= COOLDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q   <= cfg_data[FRAME_W-1:0];
				REG_FRAME_HEIGHT: fh_q   <= cfg_data[FRAME_W-1:0];
				REG_COOLDOWN:     cool_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Line table: {enable, mask, by, bx, ay, ax}.
	always_comb begin
		lr_we    = 1'b0;
		lr_waddr = SLOT_AW'(32'(in_cam) * LINES + 32'(in_idx));
		lr_wdata = {s_tdata[94], s_tdata[93:78], s_tdata[77:62], s_tdata[61:46],
			s_tdata[45:30], s_tdata[29:14]};
		if (state_q == S_CLEAR) begin
			lr_we    = 32'(clr_q) < SLOTS;
			lr_waddr = clr_q[SLOT_AW-1:0];
			lr_wdata = '0;
		end else if (in_acc && cam_ok && s_tuser == FUNC_LOAD && 32'(in_idx) < LINES) begin
			lr_we = 1'b1;
		end
	end
	assign lr_re    = (state_q == S_RDLINE);
	assign lr_raddr = SLOT_AW'(32'(it_cam_q) * LINES + 32'(l_q));

	lcd_ram #(.WIDTH(LINE_ENT_W), .DEPTH(SLOTS)) u_line_ram (
		.clk(clk), .we(lr_we), .waddr(lr_waddr), .wdata(lr_wdata),
		.re(lr_re), .raddr(lr_raddr), .rdata(lr_rdata)
	);

	assign age   = $signed({1'b0, it_ts_q}) - $signed({1'b0, fr_rdata[TS_W-1:0]});
	assign fired = !(fr_rdata[TS_W] && age < $signed({1'b0, cd}));

	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = fire_addr_q;
		fr_wdata = {1'b1, it_ts_q};
		if (state_q == S_CLEAR) begin
			fr_we    = 1'b1;
			fr_waddr = clr_q;
			fr_wdata = '0;
		end else if (state_q == S_FIRE) begin
			fr_we = fired;
		end
	end
	assign fr_re = (state_q == S_GEOM);

	lcd_ram #(.WIDTH(FIRE_ENT_W), .DEPTH(FIRE_DEPTH)) u_fire_ram (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.re(fr_re), .raddr(fire_addr_q), .rdata(fr_rdata)
	);

	assign rd_mask = lr_rdata[4*COORD_W +: MASK_W];
	assign rd_en   = lr_rdata[LINE_ENT_W-1];
	assign cls_hit = rd_en && (rd_mask == MASK_ALL ||
		(32'(it_cls_q) < CLASSES && rd_mask[it_cls_q]));

	// Operand selection for the shared multiplier.
	always_comb begin
		sax = $signed({5'b0, ax_q});
		say = $signed({5'b0, ay_q});
		sbx = $signed({5'b0, bx_q});
		sby = $signed({5'b0, by_q});
		p1x = $signed({2'b0, it_x0_q, 16'b0});
		p1y = $signed({2'b0, it_y0_q, 16'b0});
		p2x = $signed({2'b0, it_x1_q, 16'b0});
		p2y = $signed({2'b0, it_y1_q, 16'b0});
		bax = sbx - sax;
		bay = sby - say;
		dpx = $signed({2'b0, it_x1_q}) - $signed({2'b0, it_x0_q});
		dpy = $signed({2'b0, it_y1_q}) - $signed({2'b0, it_y0_q});
		mctl.mul_en = (state_q == S_MUL) && !ph_q;
		mctl.acc_en = (state_q == S_MUL) && ph_q;
		mctl.clr = 1'b0;
		mctl.hi  = 1'b0;
		mctl.sub = 1'b0;
		op_a = '0;
		op_b = '0;
		case (step_q)
			4'd0: begin op_a = $signed({21'b0, fw_q}); op_b = $signed({2'b0, e_ax_q}); mctl.clr = 1'b1; end
			4'd1: begin op_a = $signed({21'b0, fh_q}); op_b = $signed({2'b0, e_ay_q}); mctl.clr = 1'b1; end
			4'd2: begin op_a = $signed({21'b0, fw_q}); op_b = $signed({2'b0, e_bx_q}); mctl.clr = 1'b1; end
			4'd3: begin op_a = $signed({21'b0, fh_q}); op_b = $signed({2'b0, e_by_q}); mctl.clr = 1'b1; end
			4'd4: begin op_a = p1y - say; op_b = $signed({2'b0, bax[15:0]}); mctl.clr = 1'b1; end
			4'd5: begin op_a = p1y - say; op_b = bax[33:16]; mctl.hi = 1'b1; end
			4'd6: begin op_a = p1x - sax; op_b = $signed({2'b0, bay[15:0]}); mctl.sub = 1'b1; end
			4'd7: begin op_a = p1x - sax; op_b = bay[33:16]; mctl.hi = 1'b1; mctl.sub = 1'b1; end
			4'd8: begin op_a = p2y - say; op_b = $signed({2'b0, bax[15:0]}); mctl.clr = 1'b1; end
			4'd9: begin op_a = p2y - say; op_b = bax[33:16]; mctl.hi = 1'b1; end
			4'd10: begin op_a = p2x - sax; op_b = $signed({2'b0, bay[15:0]}); mctl.sub = 1'b1; end
			4'd11: begin op_a = p2x - sax; op_b = bay[33:16]; mctl.hi = 1'b1; mctl.sub = 1'b1; end
			4'd12: begin op_a = say - p1y; op_b = dpx; mctl.clr = 1'b1; end
			4'd13: begin op_a = sax - p1x; op_b = dpy; mctl.sub = 1'b1; end
			4'd14: begin op_a = sby - p1y; op_b = dpx; mctl.clr = 1'b1; end
			4'd15: begin op_a = sbx - p1x; op_b = dpy; mctl.sub = 1'b1; end
			default: ;
		endcase
	end

	lcd_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(op_a), .b(op_b), .acc_nxt(acc_nxt)
	);

	assign acc_neg = acc_nxt[ACC_W-1];
	assign acc_pos = !acc_nxt[ACC_W-1] && (acc_nxt != '0);

	assign n_nxt     = (state_q == S_FIRE && fired) ? n_q + 1'b1 : n_q;
	assign last_line = (l_q == LINE_AW'(LINES - 1));
	assign done_nxt  = last_line || (n_nxt == OUT_CNT_W'(OUT_MAX));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == FIRE_AW'(FIRE_DEPTH - 1)) state_nxt = S_IDLE;
			S_IDLE: begin
				if (in_acc && cam_ok && s_tuser == FUNC_CHECK && 32'(in_idx) < TRACKS
					&& fw_q != '0 && fh_q != '0 && !s_tdata[13]
					&& (s_tdata[29:14] != s_tdata[61:46] || s_tdata[45:30] != s_tdata[77:62]))
				begin
					state_nxt = S_RDLINE;
				end
			end
			S_RDLINE: state_nxt = S_CHKF;
			S_CHKF: begin
				if (cls_hit) begin
					state_nxt = S_MUL;
				end else if (done_nxt) begin
					state_nxt = (n_nxt != '0) ? S_EMIT : S_IDLE;
				end else begin
					state_nxt = S_RDLINE;
				end
			end
			S_MUL: if (ph_q && step_q == 4'd15) state_nxt = S_GEOM;
			S_GEOM: begin
				if (((d1p_q && d2n_q) || (d1n_q && d2p_q)) &&
					((d3p_q && d4n_q) || (d3n_q && d4p_q))) begin
					state_nxt = S_FIRE;
				end else if (done_nxt) begin
					state_nxt = (n_nxt != '0) ? S_EMIT : S_IDLE;
				end else begin
					state_nxt = S_RDLINE;
				end
			end
			S_FIRE: begin
				if (done_nxt) begin
					state_nxt = (n_nxt != '0) ? S_EMIT : S_IDLE;
				end else begin
					state_nxt = S_RDLINE;
				end
			end
			S_EMIT: if ((!m_tvalid || m_tready) && e_q + 1'b1 == n_q) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			l_q     <= '0;
			n_q     <= '0;
			e_q     <= '0;
			step_q  <= '0;
			ph_q    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_IDLE) begin
				l_q <= '0;
				e_q <= '0;
			end
			if (state_q == S_CHKF) begin
				step_q <= '0;
				ph_q   <= 1'b0;
			end
			if (state_q == S_MUL) begin
				ph_q <= !ph_q;
				if (ph_q) begin
					step_q <= step_q + 1'b1;
				end
			end
			if ((state_q == S_CHKF || state_q == S_GEOM || state_q == S_FIRE)
				&& state_nxt == S_RDLINE) begin
				l_q <= l_q + 1'b1;
			end
			n_q <= (state_q == S_IDLE) ? '0 : n_nxt;
			if (state_q == S_EMIT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
				e_q      <= e_q + 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			it_cam_q <= in_cam;
			it_idx_q <= in_idx;
			it_cls_q <= s_tdata[12:9];
			it_x0_q  <= s_tdata[29:14];
			it_y0_q  <= s_tdata[45:30];
			it_x1_q  <= s_tdata[61:46];
			it_y1_q  <= s_tdata[77:62];
			it_ts_q  <= s_tdata[142:95];
		end
		if (state_q == S_CHKF) begin
			e_ax_q <= lr_rdata[15:0];
			e_ay_q <= lr_rdata[31:16];
			e_bx_q <= lr_rdata[47:32];
			e_by_q <= lr_rdata[63:48];
		end
		if (mctl.acc_en) begin
			case (step_q)
				4'd0: ax_q <= acc_nxt[SCALED_W-1:0];
				4'd1: ay_q <= acc_nxt[SCALED_W-1:0];
				4'd2: bx_q <= acc_nxt[SCALED_W-1:0];
				4'd3: by_q <= acc_nxt[SCALED_W-1:0];
				4'd7: begin d1p_q <= acc_pos; d1n_q <= acc_neg; end
				4'd11: begin d2p_q <= acc_pos; d2n_q <= acc_neg; end
				4'd13: begin d3p_q <= acc_pos; d3n_q <= acc_neg; end
				4'd15: begin d4p_q <= acc_pos; d4n_q <= acc_neg; end
				default: ;
			endcase
		end
		if (state_q == S_CHKF) begin
			fire_addr_q <= FIRE_AW'((32'(it_cam_q) * LINES + 32'(l_q)) * TRACKS
				+ 32'(it_idx_q));
		end
		if (state_q == S_FIRE && fired) begin
			res_line_q[n_q[OUT_IDX_W-1:0]] <= l_q;
			res_dir_q[n_q[OUT_IDX_W-1:0]]  <= !d1p_q;
		end
		if (state_q == S_EMIT && (!m_tvalid || m_tready)) begin
			m_tdata <= {7'b0, res_dir_q[e_q[OUT_IDX_W-1:0]], it_idx_q,
				2'(res_line_q[e_q[OUT_IDX_W-1:0]])};
			m_tlast <= (e_q + 1'b1 == n_q);
		end
	end

	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= OUT_CNT_W'(OUT_MAX))
		else $error("crossing count exceeds limit");

	a_geom_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GEOM |-> $past(state_q) == S_MUL && $past(step_q) == 4'd15)
		else $error("geometry decision without full multiply sequence");

	a_fire_cross: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE |-> ((d1p_q && d2n_q) || (d1n_q && d2p_q)))
		else $error("cooldown lookup without side change");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> n_q != '0 && e_q < n_q)
		else $error("emission with no pending crossing");

endmodule

/* design/lcd_ram.sv */
// Generic single-port-write, registered-read RAM.
module lcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/lcd_mac.sv */
// Shared multiply-accumulate unit with a registered product stage.
module lcd_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lcd_pkg::mac_ctl_t                    ctl,
	input  logic signed [lcd_pkg::OP_A_W-1:0]    a,
	input  logic signed [lcd_pkg::OP_B_W-1:0]    b,
	output logic signed [lcd_pkg::ACC_W-1:0]     acc_nxt
);
	import lcd_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     clr_s1;
	logic                     hi_s1;
	logic                     sub_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  term;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_s1 <= 1'b0;
			hi_s1  <= 1'b0;
			sub_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (ctl.mul_en) begin
				clr_s1 <= ctl.clr;
				hi_s1  <= ctl.hi;
				sub_s1 <= ctl.sub;
			end
			if (ctl.acc_en) begin
				acc_q <= acc_nxt;
			end
		end
	end

	always_comb begin
		base = clr_s1 ? '0 : acc_q;
		term = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		if (hi_s1) begin
			term = term <<< 16;
		end
		acc_nxt = sub_s1 ? base - term : base + term;
	end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the line crossing detector: directed and random items.
module testbench;
	import lcd_pkg::*;

	localparam int N_CAM  = 8;
	localparam int N_LINE = 4;
	localparam int N_TRK  = 64;

	typedef struct packed {
		logic [1:0] line_index;
		logic [5:0] track_id;
		logic       direction;
		logic       last;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	line_crossing_detector u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the block's tables and registers.
	logic [15:0] seg_ax [N_CAM*N_LINE];
	logic [15:0] seg_ay [N_CAM*N_LINE];
	logic [15:0] seg_bx [N_CAM*N_LINE];
	logic [15:0] seg_by [N_CAM*N_LINE];
	logic [15:0] seg_mask [N_CAM*N_LINE];
	logic        seg_en [N_CAM*N_LINE];
	logic [47:0] fired_at [N_CAM*N_LINE*N_TRK];
	logic        fired [N_CAM*N_LINE*N_TRK];
	longint unsigned frame_w, frame_h, cool;

	crossing_t expected_crossings[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic longint side_val(longint px, longint py, longint ax, longint ay,
			longint bx, longint by);
		return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
	endfunction

	function automatic bit flips(longint a, longint b);
		return (a > 0 && b < 0) || (a < 0 && b > 0);
	endfunction

	task automatic predict_item(input logic fn, input logic [2:0] cam, input logic [5:0] idx,
			input logic [3:0] cls, input logic is_new, input logic [15:0] x0, y0, x1, y1,
			input logic [15:0] mask, input logic en, input logic [47:0] ts);
		int n, s, k;
		longint cd, ax, ay, bx, by, p1x, p1y, p2x, p2y, dpx, dpy, d1, d2, d3, d4;
		crossing_t c;
		n = 0;
		if (fn == FUNC_LOAD) begin
			if (idx >= N_LINE) return;
			s = cam * N_LINE + idx;
			seg_ax[s] = x0; seg_ay[s] = y0; seg_bx[s] = x1; seg_by[s] = y1;
			seg_mask[s] = mask; seg_en[s] = en;
			return;
		end
		if (frame_w == 0 || frame_h == 0) return;
		if (is_new || (x0 == x1 && y0 == y1)) return;
		cd = cool;
		if (cd < COOLDOWN_MIN) cd = COOLDOWN_MIN;
		if (cd > COOLDOWN_MAX) cd = COOLDOWN_MAX;
		p1x = longint'(x0) * 65536; p1y = longint'(y0) * 65536;
		p2x = longint'(x1) * 65536; p2y = longint'(y1) * 65536;
		dpx = longint'(x1) - longint'(x0);
		dpy = longint'(y1) - longint'(y0);
		for (int l = 0; l < N_LINE && n < OUT_MAX; l++) begin
			s = cam * N_LINE + l;
			if (!seg_en[s]) continue;
			if (seg_mask[s] != MASK_ALL && !seg_mask[s][cls]) continue;
			ax = longint'(seg_ax[s]) * longint'(frame_w);
			ay = longint'(seg_ay[s]) * longint'(frame_h);
			bx = longint'(seg_bx[s]) * longint'(frame_w);
			by = longint'(seg_by[s]) * longint'(frame_h);
			d1 = side_val(p1x, p1y, ax, ay, bx, by);
			d2 = side_val(p2x, p2y, ax, ay, bx, by);
			if (!flips(d1, d2)) continue;
			d3 = dpx * (ay - p1y) - dpy * (ax - p1x);
			d4 = dpx * (by - p1y) - dpy * (bx - p1x);
			if (!flips(d3, d4)) continue;
			k = s * N_TRK + idx;
			if (fired[k] && (longint'(ts) - longint'(fired_at[k])) < cd) continue;
			fired[k] = 1'b1;
			fired_at[k] = ts;
			c.line_index = l[1:0];
			c.track_id = idx;
			c.direction = (d1 > 0) ? 1'b0 : 1'b1;
			c.last = 1'b0;
			expected_crossings = {expected_crossings, c};
			n++;
		end
		if (n > 0) expected_crossings[expected_crossings.size() - 1].last = 1'b1;
	endtask

	task automatic send_item(input logic fn, input logic [2:0] cam, input logic [5:0] idx,
			input logic [3:0] cls, input logic is_new, input logic [15:0] x0, y0, x1, y1,
			input logic [15:0] mask, input logic en, input logic [47:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		predict_item(fn, cam, idx, cls, is_new, x0, y0, x1, y1, mask, en, ts);
		s_tuser <= fn;
		s_tdata <= {{(IN_DATA_W - 143){1'b0}}, ts, en, mask, y1, x1, y0, x0, is_new, cls,
			idx, cam};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_line(input int cam, input int slot, input logic [15:0] ax, ay, bx, by,
			input logic [15:0] mask, input logic en);
		send_item(FUNC_LOAD, 3'(cam), 6'(slot), 4'($urandom), 1'($urandom), ax, ay, bx, by,
			mask, en, 48'({$urandom, $urandom}));
	endtask

	task automatic check_track(input int cam, input int trk, input int cls, input logic is_new,
			input logic [15:0] x0, y0, x1, y1, input logic [47:0] ts);
		send_item(FUNC_CHECK, 3'(cam), 6'(trk), 4'(cls), is_new, x0, y0, x1, y1,
			16'($urandom), 1'($urandom), ts);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_crossings.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: frame_w = val & 16'h1FFF;
			REG_FRAME_HEIGHT: frame_h = val & 16'h1FFF;
			default: cool = val;
		endcase
	endtask

	// Receiver with random stalls; compares each crossing with the oldest expectation.
	always @(posedge clk) begin
		crossing_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[1:0], m_tdata[7:2], m_tdata[8], m_tlast};
			if (expected_crossings.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected crossing %h", got);
			end else begin
				want = expected_crossings.pop_front();
				if (got !== want || m_tdata[15:9] !== 7'd0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected line %0d track %0d dir %0d last %0d,",
							want.line_index, want.track_id, want.direction, want.last,
							" got line %0d track %0d dir %0d last %0d",
							got.line_index, got.track_id, got.direction, got.last);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic test_extremes();
		// Diagonal-free vertical line at mid-frame on camera 0 slot 0, all classes.
		load_line(0, 0, 16'h8000, 16'h0000, 16'h8000, 16'hFFFF, MASK_ALL, 1'b1);
		load_line(0, 1, 16'h0000, 16'h8000, 16'hFFFF, 16'h8000, 16'h0004, 1'b1);
		load_line(0, 2, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
		load_line(0, 3, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 1'b1);
		load_line(0, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, MASK_ALL, 1'b1);
		check_track(0, 5, 2, 1'b0, 100, 100, 1800, 1000, 48'd0);
		check_track(0, 5, 2, 1'b0, 1800, 1000, 100, 100, 48'd10);
		check_track(0, 5, 15, 1'b0, 1800, 1000, 100, 100, 48'd20000);
		check_track(0, 6, 2, 1'b1, 100, 100, 1800, 1000, 48'd0);
		check_track(0, 6, 2, 1'b0, 300, 300, 300, 300, 48'd0);
		check_track(0, 63, 2, 1'b0, 960, 0, 960, 1080, 48'd0);
		check_track(0, 0, 2, 1'b0, 0, 0, 65535, 65535, 48'hFFFF_FFFF_FFFF);
		check_track(0, 0, 2, 1'b0, 65535, 0, 0, 65535, 48'd5);
		check_track(1, 1, 0, 1'b0, 100, 100, 1800, 1000, 48'd0);
		check_track(0, 7, 3, 1'b0, 100, 540, 1800, 540, 48'd100);
	endtask

	task automatic test_random(input int count, input int frame_max);
		logic [15:0] ax, ay, bx, by, mask;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(4) == 0) begin
				ax = 16'($urandom); ay = 16'($urandom);
				bx = 16'($urandom); by = 16'($urandom);
				mask = ($urandom_range(2) == 0) ? MASK_ALL : 16'($urandom);
				load_line($urandom_range(N_CAM - 1), $urandom_range(5), ax, ay, bx, by,
					mask, $urandom_range(3) != 0);
			end else begin
				ax = 16'($urandom_range(frame_max)); ay = 16'($urandom_range(frame_max));
				bx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(frame_max));
				by = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(frame_max));
				check_track($urandom_range(N_CAM - 1), $urandom_range(N_TRK - 1),
					$urandom_range(15), $urandom_range(9) == 0, ax, ay, bx, by,
					($urandom_range(19) == 0) ? 48'({$urandom, $urandom})
						: 48'($urandom_range(200000)));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < N_CAM * N_LINE; i++) begin
			seg_en[i] = 1'b0; seg_mask[i] = '0;
		end
		for (int i = 0; i < N_CAM * N_LINE * N_TRK; i++) fired[i] = 1'b0;
		frame_w = FRAME_WIDTH_RST; frame_h = FRAME_HEIGHT_RST; cool = COOLDOWN_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		// Let everything settle, then load every slot so all slots are defined.
		drain();
		for (int c = 0; c < N_CAM; c++)
			for (int l = 0; l < N_LINE; l++)
				load_line(c, l, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					MASK_ALL, 1'b1);
		test_random(40, 2000);
		send_idle_pct = 51;
		test_random(50, 2000);
		drain();
		write_reg(REG_FRAME_WIDTH, 16'd4096);
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		write_reg(REG_COOLDOWN, 16'd0);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		test_random(50, 4100);
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'd4096);
		write_reg(REG_COOLDOWN, 16'hFFFF);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		test_random(50, 4100);
		write_reg(REG_FRAME_WIDTH, 16'd0);
		test_random(10, 2000);
		write_reg(REG_FRAME_WIDTH, 16'd640);
		write_reg(REG_FRAME_HEIGHT, 16'd480);
		write_reg(REG_COOLDOWN, 16'd100);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(25, 700);
		drain();
		if (errors == 0 && expected_crossings.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end
endmodule
